@@ design/rrs_pkg.sv @@
// shared types and codes for the round-robin slot scheduler
// no dependencies
`default_nettype none
package rrs_pkg;

  localparam int SLOTS   = 32;
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int FRONT_W = 6;

  localparam logic [FRONT_W-1:0] FRONT_NONE = FRONT_W'(SLOTS);

  // command kinds
  localparam logic [2:0] K_TICK    = 3'd0;
  localparam logic [2:0] K_REG     = 3'd1;
  localparam logic [2:0] K_UNREG   = 3'd2;
  localparam logic [2:0] K_SWITCH  = 3'd3;
  localparam logic [2:0] K_SUSPEND = 3'd4;
  localparam logic [2:0] K_RESUME  = 3'd5;

  // slot modes
  localparam logic [2:0] M_INACTIVE = 3'd0;
  localparam logic [2:0] M_FRONT    = 3'd1;
  localparam logic [2:0] M_BACK     = 3'd2;
  localparam logic [2:0] M_SUSP     = 3'd4;

  // result status
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NULL     = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_MULTI = 2'd0;
  localparam logic [1:0] CFG_COOP  = 2'd1;
  localparam logic [1:0] CFG_FRONT = 2'd2;
  localparam logic [1:0] CFG_BACK  = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] app_handle;
    logic [31:0] app_signature;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [FRONT_W-1:0] front_slot;
    logic [15:0]        task_id;
    logic               switched;
    logic [5:0]         live_tasks;
  } out_t;

endpackage
`default_nettype wire

@@ design/round_robin_slot_scheduler.sv @@
// round-robin slot scheduler: command sequencer over a 32-slot task table
// depends on rrs_pkg
`default_nettype none
// One command beat is taken at a time; in_stall stays high until its result
// beat is loaded into the output register. All table access goes through one
// slot address register, and a small sequencer walks it one slot per cycle,
// so the cost of a command is set by its slot scans. Register and the handle
// commands search the table slot by slot for a free or a matching slot.
// Unregister or suspend of the front task adds a round-robin scan over the
// slots and a switch. A tick that expires the front slice with coop_r set
// adds a round-robin scan, and every fourth tick adds a background refill
// pass over all 32 slots. A plain tick only counts down the front slice;
// an ignored or bad command goes straight to the result beat.
module round_robin_slot_scheduler (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire rrs_pkg::in_t     in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output rrs_pkg::out_t         out_data,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [7:0]       cfg_wdata
);

  localparam int IW = rrs_pkg::IDX_W;

  typedef enum logic [3:0] {
    S_IDLE, S_TDEC, S_PICK, S_PICKED, S_SW1, S_SW2, S_FIND, S_FREE,
    S_UNREG, S_REFCHK, S_REF, S_DONE
  } state_t;

  // slot table, all read and written at addr_r
  logic [2:0]  mode_r  [rrs_pkg::SLOTS];
  logic [31:0] key_r   [rrs_pkg::SLOTS];
  logic [31:0] sig_r   [rrs_pkg::SLOTS];
  logic [7:0]  ticks_r [rrs_pkg::SLOTS];
  logic [15:0] ident_r [rrs_pkg::SLOTS];

  state_t state_r, state_nxt;
  logic [IW-1:0] addr_r, addr_nxt, cnt_r, cnt_nxt, p_r, p_nxt, nx_r, nx_nxt;
  logic nx_found_r, nx_found_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic [31:0] handle_r, handle_nxt, sgn_r, sgn_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [15:0] id_r, id_nxt, next_id_r, next_id_nxt;
  logic        sw_r, sw_nxt;
  logic [rrs_pkg::FRONT_W-1:0] front_r, front_nxt;
  logic [5:0]  occ_r, occ_nxt;
  logic [1:0]  tick2_r, tick2_nxt;
  logic        multi_r, coop_r;
  logic [7:0]  fslice_r, bslice_r;
  rrs_pkg::out_t out_r;
  logic        out_valid_r;

  // table write controls
  logic       we_mode, we_ticks, we_ent;
  logic [2:0] mode_wd;
  logic [7:0] ticks_wd;

  logic [2:0]    mode_rd;
  logic [7:0]    ticks_rd, ticks_dec;
  logic          runnable, last, front_none;
  logic [IW-1:0] addr_adv, front_idx;

  assign mode_rd    = mode_r[addr_r];
  assign ticks_rd   = ticks_r[addr_r];
  assign ticks_dec  = (ticks_rd != 8'd0) ? ticks_rd - 8'd1 : 8'd0;
  assign runnable   = (mode_rd == rrs_pkg::M_FRONT) || (mode_rd == rrs_pkg::M_BACK);
  assign last       = (cnt_r == IW'(rrs_pkg::SLOTS - 1));
  assign addr_adv   = (addr_r == IW'(rrs_pkg::SLOTS - 1)) ? '0 : addr_r + 1'b1;
  assign front_none = (front_r == rrs_pkg::FRONT_NONE);
  assign front_idx  = front_r[IW-1:0];

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt    = state_r;
    addr_nxt     = addr_r;
    cnt_nxt      = cnt_r;
    p_nxt        = p_r;
    nx_nxt       = nx_r;
    nx_found_nxt = nx_found_r;
    kind_nxt     = kind_r;
    handle_nxt   = handle_r;
    sgn_nxt      = sgn_r;
    status_nxt   = status_r;
    id_nxt       = id_r;
    sw_nxt       = sw_r;
    front_nxt    = front_r;
    occ_nxt      = occ_r;
    next_id_nxt  = next_id_r;
    tick2_nxt    = tick2_r;
    we_mode      = 1'b0;
    we_ticks     = 1'b0;
    we_ent       = 1'b0;
    mode_wd      = rrs_pkg::M_INACTIVE;
    ticks_wd     = 8'd0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt   = in_data.kind;
          handle_nxt = in_data.app_handle;
          sgn_nxt    = in_data.app_signature;
          status_nxt = rrs_pkg::ST_OK;
          id_nxt     = 16'd0;
          sw_nxt     = 1'b0;
          cnt_nxt    = '0;
          addr_nxt   = '0;
          state_nxt  = S_DONE;
          if (in_data.kind == rrs_pkg::K_TICK) begin
            if (multi_r) begin
              tick2_nxt = tick2_r + 2'd1;
              if (front_none) begin
                state_nxt = S_REFCHK;
              end else begin
                addr_nxt  = front_idx;
                state_nxt = S_TDEC;
              end
            end
          end else if (in_data.kind <= rrs_pkg::K_RESUME) begin
            if (in_data.app_handle == 32'd0) begin
              status_nxt = rrs_pkg::ST_NULL;
            end else if (in_data.kind == rrs_pkg::K_REG) begin
              state_nxt = S_FREE;
            end else begin
              state_nxt = S_FIND;
            end
          end
        end
      end
      S_TDEC: begin
        // count down the front slice
        we_ticks = 1'b1;
        ticks_wd = ticks_dec;
        if (ticks_dec == 8'd0 && coop_r) begin
          cnt_nxt   = '0;
          addr_nxt  = addr_adv;
          state_nxt = S_PICK;
        end else begin
          state_nxt = S_REFCHK;
        end
      end
      S_PICK: begin
        // round-robin scan from the slot after the front
        if (runnable) begin
          nx_nxt       = addr_r;
          nx_found_nxt = 1'b1;
          state_nxt    = S_PICKED;
        end else if (last) begin
          nx_found_nxt = 1'b0;
          state_nxt    = S_PICKED;
        end else begin
          cnt_nxt  = cnt_r + 1'b1;
          addr_nxt = addr_adv;
        end
      end
      S_PICKED: begin
        if (nx_found_r && nx_r == front_idx) begin
          // front is the only runnable task
          if (kind_r == rrs_pkg::K_TICK) begin
            we_ticks  = 1'b1;
            ticks_wd  = fslice_r;
            state_nxt = S_REFCHK;
          end else begin
            front_nxt = rrs_pkg::FRONT_NONE;
            addr_nxt  = p_r;
            state_nxt = S_UNREG;
          end
        end else if (!nx_found_r && kind_r == rrs_pkg::K_SUSPEND) begin
          state_nxt = S_DONE;
        end else if (!nx_found_r && kind_r == rrs_pkg::K_UNREG) begin
          front_nxt = rrs_pkg::FRONT_NONE;
          addr_nxt  = p_r;
          state_nxt = S_UNREG;
        end else begin
          addr_nxt  = front_idx;
          state_nxt = S_SW1;
        end
      end
      S_SW1: begin
        // old front drops to background unless suspended
        if (mode_rd == rrs_pkg::M_FRONT) begin
          we_mode = 1'b1;
          mode_wd = rrs_pkg::M_BACK;
        end
        if (nx_found_r) begin
          addr_nxt  = nx_r;
          state_nxt = S_SW2;
        end else begin
          front_nxt = rrs_pkg::FRONT_NONE;
          sw_nxt    = 1'b1;
          state_nxt = (kind_r == rrs_pkg::K_TICK) ? S_REFCHK : S_DONE;
        end
      end
      S_SW2: begin
        we_mode   = 1'b1;
        mode_wd   = rrs_pkg::M_FRONT;
        we_ticks  = 1'b1;
        ticks_wd  = fslice_r;
        front_nxt = {1'b0, addr_r};
        sw_nxt    = 1'b1;
        if (kind_r == rrs_pkg::K_TICK) begin
          state_nxt = S_REFCHK;
        end else if (kind_r == rrs_pkg::K_UNREG) begin
          addr_nxt  = p_r;
          state_nxt = S_UNREG;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_FIND: begin
        // lowest live slot holding the handle
        if (mode_rd != rrs_pkg::M_INACTIVE && key_r[addr_r] == handle_r) begin
          p_nxt     = addr_r;
          id_nxt    = ident_r[addr_r];
          state_nxt = S_DONE;
          case (kind_r)
            rrs_pkg::K_UNREG: begin
              if (!front_none && front_idx == addr_r) begin
                cnt_nxt   = '0;
                addr_nxt  = addr_adv;
                state_nxt = S_PICK;
              end else begin
                state_nxt = S_UNREG;
              end
            end
            rrs_pkg::K_SWITCH: begin
              nx_nxt       = addr_r;
              nx_found_nxt = 1'b1;
              if (front_none) begin
                state_nxt = S_SW2;
              end else if (front_idx != addr_r) begin
                addr_nxt  = front_idx;
                state_nxt = S_SW1;
              end
            end
            rrs_pkg::K_SUSPEND: begin
              we_mode = 1'b1;
              mode_wd = rrs_pkg::M_SUSP;
              if (!front_none && front_idx == addr_r) begin
                cnt_nxt   = '0;
                addr_nxt  = addr_adv;
                state_nxt = S_PICK;
              end
            end
            rrs_pkg::K_RESUME: begin
              we_mode = 1'b1;
              if (front_none) begin
                mode_wd   = rrs_pkg::M_FRONT;
                front_nxt = {1'b0, addr_r};
              end else begin
                mode_wd = rrs_pkg::M_BACK;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end else if (last) begin
          status_nxt = rrs_pkg::ST_NOTFOUND;
          state_nxt  = S_DONE;
        end else begin
          cnt_nxt  = cnt_r + 1'b1;
          addr_nxt = addr_adv;
        end
      end
      S_FREE: begin
        // lowest free slot takes the new task
        if (mode_rd == rrs_pkg::M_INACTIVE) begin
          we_ent      = 1'b1;
          we_mode     = 1'b1;
          we_ticks    = 1'b1;
          id_nxt      = next_id_r;
          next_id_nxt = next_id_r + 16'd1;
          occ_nxt     = occ_r + 6'd1;
          if (front_none) begin
            front_nxt = {1'b0, addr_r};
            mode_wd   = rrs_pkg::M_FRONT;
            ticks_wd  = fslice_r;
          end else begin
            mode_wd  = rrs_pkg::M_BACK;
            ticks_wd = bslice_r;
          end
          state_nxt = S_DONE;
        end else if (last) begin
          status_nxt = rrs_pkg::ST_FULL;
          state_nxt  = S_DONE;
        end else begin
          cnt_nxt  = cnt_r + 1'b1;
          addr_nxt = addr_adv;
        end
      end
      S_UNREG: begin
        we_mode   = 1'b1;
        mode_wd   = rrs_pkg::M_INACTIVE;
        we_ticks  = 1'b1;
        ticks_wd  = 8'd0;
        occ_nxt   = (occ_r != 6'd0) ? occ_r - 6'd1 : occ_r;
        state_nxt = S_DONE;
      end
      S_REFCHK: begin
        // every fourth tick refills background slices
        cnt_nxt   = '0;
        addr_nxt  = '0;
        state_nxt = (tick2_r == 2'd0) ? S_REF : S_DONE;
      end
      S_REF: begin
        if (mode_rd == rrs_pkg::M_BACK) begin
          we_ticks = 1'b1;
          ticks_wd = bslice_r;
        end
        if (last) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt  = cnt_r + 1'b1;
          addr_nxt = addr_adv;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // slot table storage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rrs_pkg::SLOTS; i++) begin
        mode_r[i] <= rrs_pkg::M_INACTIVE;
      end
    end else if (we_mode) begin
      mode_r[addr_r] <= mode_wd;
    end
    if (we_ticks) begin
      ticks_r[addr_r] <= ticks_wd;
    end
    if (we_ent) begin
      key_r[addr_r]   <= handle_r;
      sig_r[addr_r]   <= sgn_r;
      ident_r[addr_r] <= next_id_r;
    end
  end

  // sequencer state, configuration and result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= rrs_pkg::FRONT_NONE;
      occ_r       <= 6'd0;
      next_id_r   <= 16'd1;
      tick2_r     <= 2'd1;
      multi_r     <= 1'b1;
      coop_r      <= 1'b1;
      fslice_r    <= 8'd16;
      bslice_r    <= 8'd4;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      front_r   <= front_nxt;
      occ_r     <= occ_nxt;
      next_id_r <= next_id_nxt;
      tick2_r   <= tick2_nxt;
      if (cfg_we) begin
        case (cfg_index)
          rrs_pkg::CFG_MULTI: multi_r  <= cfg_wdata[0];
          rrs_pkg::CFG_COOP:  coop_r   <= cfg_wdata[0];
          rrs_pkg::CFG_FRONT: fslice_r <= cfg_wdata;
          rrs_pkg::CFG_BACK:  bslice_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    addr_r     <= addr_nxt;
    cnt_r      <= cnt_nxt;
    p_r        <= p_nxt;
    nx_r       <= nx_nxt;
    nx_found_r <= nx_found_nxt;
    kind_r     <= kind_nxt;
    handle_r   <= handle_nxt;
    sgn_r      <= sgn_nxt;
    status_r   <= status_nxt;
    id_r       <= id_nxt;
    sw_r       <= sw_nxt;
    if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
      out_r.status     <= status_r;
      out_r.front_slot <= front_r;
      out_r.task_id    <= id_r;
      out_r.switched   <= sw_r;
      out_r.live_tasks <= occ_r;
    end
  end

endmodule
`default_nettype wire

@@ sim/round_robin_slot_scheduler_tb.sv @@
// testbench for the round-robin slot scheduler: directed and random command beats,
// checked against a behavioral scheduler model kept inside this module
// depends on rrs_pkg and round_robin_slot_scheduler
`default_nettype none
module round_robin_slot_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rrs_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_wdata = '0;

  always #4 clk = ~clk;

  round_robin_slot_scheduler dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // scheduler model state
  logic [31:0] sk_key [SLOTS];
  logic [2:0]  sk_mode [SLOTS];
  logic [7:0]  sk_ticks [SLOTS];
  logic [15:0] sk_ident [SLOTS];
  logic [15:0] sk_next_ident;
  int          sk_front;
  logic [31:0] sk_tick_count;
  int          sk_live;
  logic        sk_multi, sk_coop;
  logic [7:0]  sk_fslice, sk_bslice;

  in_t  cmd_queue[$];
  out_t expected_results[$];
  int   error_count = 0;
  bit   stim_done = 1'b0;
  bit   idle_free = 1'b0;     // last part of the run: no idling
  bit   hold_request = 1'b0;  // asks the receiver for a long hold-off
  bit   hold_taken = 1'b0;    // receiver has started that hold-off
  int   quiet_cycles = 0;

  // small handle pool so lookups hit often
  logic [31:0] handle_pool [8];

  function automatic int sched_pick_next();
    int start;
    int idx;
    start = (sk_front >= SLOTS) ? 0 : sk_front + 1;
    for (int i = 0; i < SLOTS; i++) begin
      idx = (start + i) % SLOTS;
      if (sk_mode[idx] == M_BACK || sk_mode[idx] == M_FRONT) return idx;
    end
    return SLOTS;
  endfunction

  function automatic logic sched_switch(int from, int to);
    if (from == to && from < SLOTS) return 1'b0;
    if (from < SLOTS && sk_mode[from] == M_FRONT) sk_mode[from] = M_BACK;
    if (to < SLOTS) begin
      sk_mode[to] = M_FRONT;
      sk_ticks[to] = sk_fslice;
    end
    sk_front = to;
    return 1'b1;
  endfunction

  function automatic void sched_reset();
    for (int i = 0; i < SLOTS; i++) begin
      sk_key[i] = '0; sk_mode[i] = M_INACTIVE; sk_ticks[i] = '0; sk_ident[i] = '0;
    end
    sk_next_ident = 16'd1;
    sk_front = SLOTS;
    sk_tick_count = 32'd1;
    sk_live = 0;
    sk_multi = 1'b1; sk_coop = 1'b1; sk_fslice = 8'd16; sk_bslice = 8'd4;
  endfunction

  // applies one command to the model and returns the result beat it causes
  function automatic out_t sched_apply(in_t c);
    out_t r;
    int p;
    int nx;
    int f;
    r = '0;
    r.status = ST_OK;
    if (c.kind == K_TICK) begin
      if (sk_multi) begin
        sk_tick_count++;
        if (sk_front < SLOTS) begin
          f = sk_front;
          if (sk_ticks[f] > 0) sk_ticks[f]--;
          if (sk_ticks[f] == 0 && sk_coop) begin
            nx = sched_pick_next();
            if (nx != f) r.switched = sched_switch(f, nx);
            else sk_ticks[f] = sk_fslice;
          end
        end
        if (sk_tick_count[1:0] == 2'b00)
          for (int i = 0; i < SLOTS; i++)
            if (sk_mode[i] == M_BACK) sk_ticks[i] = sk_bslice;
      end
    end else if (c.kind <= K_RESUME) begin
      if (c.app_handle == 0) begin
        r.status = ST_NULL;
      end else if (c.kind == K_REG) begin
        p = SLOTS;
        for (int i = 0; i < SLOTS; i++)
          if (p == SLOTS && sk_mode[i] == M_INACTIVE) p = i;
        if (p == SLOTS) begin
          r.status = ST_FULL;
        end else begin
          sk_key[p] = c.app_handle;
          sk_ident[p] = sk_next_ident;
          r.task_id = sk_next_ident;
          sk_next_ident++;
          sk_live++;
          if (sk_front >= SLOTS) begin
            sk_front = p; sk_mode[p] = M_FRONT; sk_ticks[p] = sk_fslice;
          end else begin
            sk_mode[p] = M_BACK; sk_ticks[p] = sk_bslice;
          end
        end
      end else begin
        p = SLOTS;
        for (int i = 0; i < SLOTS; i++)
          if (p == SLOTS && sk_key[i] == c.app_handle) p = i;
        if (p == SLOTS) begin
          r.status = ST_NOTFOUND;
        end else begin
          r.task_id = sk_ident[p];
          case (c.kind)
            K_UNREG: begin
              if (sk_front == p) begin
                nx = sched_pick_next();
                if (nx < SLOTS && nx != p) r.switched = sched_switch(p, nx);
                else sk_front = SLOTS;
              end
              sk_key[p] = '0; sk_mode[p] = M_INACTIVE; sk_ticks[p] = '0; sk_ident[p] = '0;
              if (sk_live > 0) sk_live--;
            end
            K_SWITCH: r.switched = sched_switch(sk_front, p);
            K_SUSPEND: begin
              sk_mode[p] = M_SUSP;
              if (sk_front == p) begin
                nx = sched_pick_next();
                if (nx < SLOTS) r.switched = sched_switch(p, nx);
              end
            end
            default: begin
              if (sk_front >= SLOTS) begin
                sk_mode[p] = M_FRONT; sk_front = p;
              end else begin
                sk_mode[p] = M_BACK;
              end
            end
          endcase
        end
      end
    end
    r.front_slot = FRONT_W'(sk_front);
    r.live_tasks = 6'(sk_live);
    return r;
  endfunction

  function automatic in_t make_cmd(logic [2:0] k, logic [31:0] h, logic [31:0] s);
    in_t c;
    c.kind = k; c.app_handle = h; c.app_signature = s;
    return c;
  endfunction

  // random command with mostly well-formed content drawn from the handle pool
  function automatic in_t random_cmd();
    int sel;
    logic [2:0] k;
    logic [31:0] h;
    sel = $urandom_range(0, 99);
    if (sel < 40) k = K_TICK;
    else if (sel < 58) k = K_REG;
    else if (sel < 70) k = K_UNREG;
    else if (sel < 80) k = K_SWITCH;
    else if (sel < 88) k = K_SUSPEND;
    else if (sel < 96) k = K_RESUME;
    else k = 3'($urandom_range(6, 7));
    sel = $urandom_range(0, 19);
    if (sel == 0) h = '0;
    else if (sel == 1) h = $urandom();
    else h = handle_pool[$urandom_range(0, 7)];
    return make_cmd(k, h, $urandom());
  endfunction

  task automatic wait_idle();
    while (cmd_queue.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MULTI: sk_multi  = val[0];
      CFG_COOP:  sk_coop   = val[0];
      CFG_FRONT: sk_fslice = val;
      default:   sk_bslice = val;
    endcase
    @(posedge clk);
  endtask

  // driver: pops pending beats, idles in random bursts
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(sched_apply(in_data));
        void'(cmd_queue.pop_front());
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if ((in_valid && !in_stall ? cmd_queue.size() > 0 : cmd_queue.size() > 0)
                     && !(in_valid && !in_stall && !idle_free
                          && $urandom_range(0, 9) == 0)) begin
          in_valid <= 1'b1;
          in_data <= cmd_queue[0];
        end else begin
          in_valid <= 1'b0;
          if (!idle_free && cmd_queue.size() > 0) send_gap <= $urandom_range(1, 12) - 1;
        end
      end
    end
  end

  // monitor: checks result beats, stalls in random bursts or long hold-offs
  int stall_left = 0;
  always @(posedge clk) begin
    out_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no expectation waiting");
          error_count++;
        end else begin
          e = expected_results.pop_front();
          if (out_data.status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, out_data.status);
            error_count++;
          end
          if (out_data.front_slot !== e.front_slot) begin
            $error("front_slot expected %0d actual %0d", e.front_slot, out_data.front_slot);
            error_count++;
          end
          if (out_data.task_id !== e.task_id) begin
            $error("task_id expected %0d actual %0d", e.task_id, out_data.task_id);
            error_count++;
          end
          if (out_data.switched !== e.switched) begin
            $error("switched expected %0d actual %0d", e.switched, out_data.switched);
            error_count++;
          end
          if (out_data.live_tasks !== e.live_tasks) begin
            $error("live_tasks expected %0d actual %0d", e.live_tasks, out_data.live_tasks);
            error_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if (hold_request && !hold_taken) begin
        // long hold-off so the block backs up onto its input
        stall_left <= 300;
        out_stall <= 1'b1;
        hold_taken <= 1'b1;
      end else if (!idle_free && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(1, 12) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else if (rst_n && !stim_done) quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [31:0] h;
    sched_reset();
    for (int i = 0; i < 8; i++) handle_pool[i] = $urandom() | 32'd1;
    handle_pool[0] = 32'hFFFF_FFFF;
    handle_pool[1] = 32'd1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: null handles, unknown kinds, not found, extremes of fields
    cmd_queue.push_back(make_cmd(K_TICK, '0, '0));
    cmd_queue.push_back(make_cmd(K_REG, '0, '1));
    cmd_queue.push_back(make_cmd(K_UNREG, 32'h1234, '0));
    cmd_queue.push_back(make_cmd(3'd6, '1, '1));
    cmd_queue.push_back(make_cmd(3'd7, '0, '0));
    cmd_queue.push_back(make_cmd(K_REG, handle_pool[0], 32'hFFFF_FFFF));
    cmd_queue.push_back(make_cmd(K_REG, handle_pool[1], 32'h0));
    cmd_queue.push_back(make_cmd(K_REG, handle_pool[1], 32'hA5A5_5A5A)); // duplicate handle
    cmd_queue.push_back(make_cmd(K_SWITCH, handle_pool[0], '0));          // switch to front
    cmd_queue.push_back(make_cmd(K_SWITCH, handle_pool[1], '0));
    cmd_queue.push_back(make_cmd(K_SUSPEND, handle_pool[0], '0));
    cmd_queue.push_back(make_cmd(K_SWITCH, handle_pool[0], '0));          // switch to suspended
    cmd_queue.push_back(make_cmd(K_RESUME, handle_pool[0], '0));          // resume the front
    for (int i = 0; i < 6; i++) cmd_queue.push_back(make_cmd(K_TICK, '1, '1));
    cmd_queue.push_back(make_cmd(K_UNREG, handle_pool[1], '0));
    cmd_queue.push_back(make_cmd(K_SUSPEND, handle_pool[1], '0));
    cmd_queue.push_back(make_cmd(K_SUSPEND, handle_pool[0], '0));        // no runnable task
    cmd_queue.push_back(make_cmd(K_RESUME, handle_pool[0], '0));
    wait_idle();

    // fill the table past full, slice extremes, then expiry on every tick
    write_reg(CFG_FRONT, 8'd1);
    write_reg(CFG_BACK, 8'd255);
    for (int i = 0; i < 34; i++) cmd_queue.push_back(make_cmd(K_REG, $urandom() | 32'd1, $urandom()));
    for (int i = 0; i < 40; i++) cmd_queue.push_back(make_cmd(K_TICK, $urandom(), $urandom()));
    wait_idle();
    write_reg(CFG_FRONT, 8'd0);
    write_reg(CFG_BACK, 8'd0);
    for (int i = 0; i < 10; i++) cmd_queue.push_back(make_cmd(K_TICK, '0, '0));
    wait_idle();

    // clear the table by unregistering in slot order
    for (int i = 0; i < SLOTS; i++)
      if (sk_key[i] != 0) cmd_queue.push_back(make_cmd(K_UNREG, sk_key[i], '0));
    wait_idle();

    // random phases over several settings
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin write_reg(CFG_FRONT, 8'd16); write_reg(CFG_BACK, 8'd4); end
        1: begin write_reg(CFG_MULTI, 8'd0); write_reg(CFG_FRONT, 8'd255); end
        2: begin write_reg(CFG_MULTI, 8'd1); write_reg(CFG_COOP, 8'd0); end
        3: begin write_reg(CFG_COOP, 8'd1); write_reg(CFG_FRONT, 8'd3);
                 write_reg(CFG_BACK, 8'd1); end
        default: begin write_reg(CFG_FRONT, 8'($urandom_range(1, 255)));
                       write_reg(CFG_BACK, 8'($urandom_range(1, 255))); end
      endcase
      if (phase == 4) idle_free = 1'b1;
      for (int i = 0; i < 80; i++) cmd_queue.push_back(random_cmd());
      if (phase == 3) begin
        while (cmd_queue.size() > 60) @(posedge clk);
        hold_request = 1'b1;
      end
      wait_idle();
    end
    stim_done = 1'b1;

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ sim.f @@
design/rrs_pkg.sv
design/round_robin_slot_scheduler.sv
sim/round_robin_slot_scheduler_tb.sv
